>>> hw/rtl/stcs_pkg.sv
package stcs_pkg;

   localparam int LINE_WIDTH_DEF = 24;
   localparam int LINE_NUM_W     = 24;
   localparam int BYTE_W         = 8;
   localparam int QUEUE_DEPTH    = 4;
   localparam int MAX_RESULTS    = 3;

   localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_BSL   = 8'h5C;
   localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
   localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
   localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;

   typedef enum logic [1:0] {
      TAIL_NONE = 2'd0,
      TAIL_CR   = 2'd1,
      TAIL_LF   = 2'd2
   } tail_type;

   typedef enum logic [1:0] {
      CM_OUT   = 2'd0,
      CM_LINE  = 2'd1,
      CM_BLOCK = 2'd2,
      CM_STAR  = 2'd3
   } cmode_type;

   typedef struct packed {
      tail_type  tail;
      logic      bsl;
      logic      slash;
      cmode_type mode;
   } scan_state_type;

   localparam scan_state_type SCAN_RESET = '{
      tail:  TAIL_NONE,
      bsl:   1'b0,
      slash: 1'b0,
      mode:  CM_OUT
   };

   typedef struct packed {
      logic [BYTE_W-1:0]     out_byte;
      logic [LINE_NUM_W-1:0] line_number;
      logic                  error;
      logic                  last;
   } rsp_entry_type;

endpackage

>>> hw/rtl/stcs_ifs.sv
interface stcs_req_if;
   import stcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface stcs_rsp_if;
   import stcs_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [BYTE_W-1:0]     out_byte;
   logic [LINE_NUM_W-1:0] line_number;
   logic                  error;
   logic                  last;

   modport source (output valid, output out_byte, output line_number, output error,
                   output last, input ready);
   modport sink (input valid, input out_byte, input line_number, input error,
                 input last, output ready);
endinterface

>>> hw/rtl/source_text_comment_stripper.sv
// channel    dir  payload                                   handshake
// req_chan   in   in_byte[7:0]                              valid/ready
// rsp_chan   out  out_byte[7:0] line_number[23:0] error last valid/ready
//
// one byte is taken per cycle while req_chan.ready is high; its results (zero to three)
// enter a four-entry result queue in the same edge and leave one per cycle while rsp_chan.ready is high
// bytes that give one result each stream at full rate while rsp_chan is not stalled; a flushed
// slash or backslash gives extra results and holds the input until the queue drains
// req_chan.ready is high while the queue holds at most one result
// reset is synchronous and clears scan state, line count and the queue
module source_text_comment_stripper #(
   parameter int LINE_WIDTH = stcs_pkg::LINE_WIDTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   stcs_req_if.sink   req_chan,
   stcs_rsp_if.source rsp_chan
);
   import stcs_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   scan_state_type        state_ff, state_in;
   logic [LINE_WIDTH-1:0] line_ff, line_in;
   rsp_entry_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [1:0]            res_n;
   logic [BYTE_W-1:0]     res_byte [MAX_RESULTS];
   logic                  res_err [MAX_RESULTS];
   logic [LINE_NUM_W-1:0] res_line;

   logic req_fire, rsp_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   // one input byte: newline folding, splice removal, then up to two logical chars
   always_comb begin : scan
      scan_state_type            st;
      logic [LINE_WIDTH-1:0]     cnt;
      logic [LINE_WIDTH+LINE_NUM_W-1:0] cnt_wide;
      logic [BYTE_W-1:0]         c;
      logic                      is_nl;
      logic                      done;
      logic [1:0]                n;
      logic [BYTE_W-1:0]         lch [2];
      logic                      lvalid [2];
      logic                      pv [2];
      logic [BYTE_W-1:0]         pb [2];
      logic                      pe [2];

      st        = state_ff;
      cnt       = line_ff;
      c         = req_chan.in_byte;
      is_nl     = (c == CH_LF) || (c == CH_CR);
      done      = 1'b0;
      n         = 2'd0;
      lch[0]    = CH_BSL;
      lch[1]    = c;
      lvalid[0] = 1'b0;
      lvalid[1] = 1'b0;
      for (int k = 0; k < MAX_RESULTS; k++) begin
         res_byte[k] = CH_NUL;
         res_err[k]  = 1'b0;
      end

      if ((state_ff.tail == TAIL_CR && c == CH_CR) ||
          (state_ff.tail == TAIL_LF && c == CH_LF)) begin
         st.tail = TAIL_NONE;
      end else begin
         st.tail = TAIL_NONE;
         if (state_ff.bsl && is_nl) begin
            st.bsl = 1'b0;
            if (cnt != '1) cnt = cnt + LINE_WIDTH'(1);
            st.tail = (c == CH_LF) ? TAIL_CR : TAIL_LF;
         end else begin
            lvalid[0] = state_ff.bsl;
            st.bsl    = 1'b0;
            if (c == CH_BSL) begin
               st.bsl = 1'b1;
            end else if (is_nl) begin
               if (cnt != '1) cnt = cnt + LINE_WIDTH'(1);
               st.tail   = (c == CH_LF) ? TAIL_CR : TAIL_LF;
               lch[1]    = CH_LF;
               lvalid[1] = 1'b1;
            end else begin
               lvalid[1] = 1'b1;
            end
         end
      end

      for (int i = 0; i < 2; i++) begin
         pv[0] = 1'b0;
         pv[1] = 1'b0;
         pb[0] = CH_SLASH;
         pb[1] = lch[i];
         pe[0] = 1'b0;
         pe[1] = 1'b0;
         if (lvalid[i] && !done) begin
            case (st.mode)
               CM_OUT: begin
                  if (st.slash) begin
                     st.slash = 1'b0;
                     if (lch[i] == CH_SLASH) begin
                        st.mode = CM_LINE;
                     end else if (lch[i] == CH_STAR) begin
                        st.mode = CM_BLOCK;
                     end else begin
                        pv[0] = 1'b1;
                        pv[1] = 1'b1;
                     end
                  end else if (lch[i] == CH_SLASH) begin
                     st.slash = 1'b1;
                  end else begin
                     pv[1] = 1'b1;
                  end
                  if (pv[1] && lch[i] == CH_NUL) done = 1'b1;
               end
               CM_LINE: begin
                  if (lch[i] == CH_LF) begin
                     pv[1]   = 1'b1;
                     st.mode = CM_OUT;
                  end else if (lch[i] == CH_NUL) begin
                     pv[1] = 1'b1;
                     done  = 1'b1;
                  end
               end
               default: begin
                  if (lch[i] == CH_NUL) begin
                     pv[1] = 1'b1;
                     pe[1] = 1'b1;
                     done  = 1'b1;
                  end else if (st.mode == CM_STAR && lch[i] == CH_SLASH) begin
                     pv[1]   = 1'b1;
                     pb[1]   = CH_SPACE;
                     st.mode = CM_OUT;
                  end else if (lch[i] == CH_STAR) begin
                     st.mode = CM_STAR;
                  end else begin
                     pv[1]   = (lch[i] == CH_LF);
                     st.mode = CM_BLOCK;
                  end
               end
            endcase
         end
         for (int j = 0; j < 2; j++) begin
            if (pv[j] && n < 2'(MAX_RESULTS)) begin
               res_byte[n] = pb[j];
               res_err[n]  = pe[j];
               n           = n + 2'd1;
            end
         end
      end

      cnt_wide = {{LINE_NUM_W{1'b0}}, cnt};
      res_line = cnt_wide[LINE_NUM_W-1:0];
      res_n    = n;
      if (done) begin
         state_in = SCAN_RESET;
         line_in  = LINE_WIDTH'(1);
      end else begin
         state_in = st;
         line_in  = cnt;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (rsp_fire) count_in = count_in - CNT_W'(1);
      if (req_fire) count_in = count_in + CNT_W'(res_n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SCAN_RESET;
         line_ff   <= LINE_WIDTH'(1);
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_fire) begin
            state_ff  <= state_in;
            line_ff   <= line_in;
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(res_n);
         end
         if (rsp_fire) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < res_n) begin
               queue_ff[wr_ptr_ff + PTR_W'(k)] <= '{
                  out_byte:    res_byte[k],
                  line_number: res_line,
                  error:       res_err[k],
                  last:        (2'(k) == res_n - 2'd1)
               };
            end
         end
      end
   end

   assign req_chan.ready       = (count_ff <= CNT_W'(1));
   assign rsp_chan.valid       = (count_ff != '0);
   assign rsp_chan.out_byte    = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_chan.line_number = queue_ff[rd_ptr_ff].line_number;
   assign rsp_chan.error       = queue_ff[rd_ptr_ff].error;
   assign rsp_chan.last        = queue_ff[rd_ptr_ff].last;

`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_item_tail_queued: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && !rsp_chan.last) |-> (count_ff >= CNT_W'(2)))
      else $error("item results split from their last flag");

   a_error_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.error) |-> (rsp_chan.out_byte == CH_NUL && rsp_chan.last))
      else $error("error flag outside end of unit");

   a_end_resets_scan: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.in_byte == CH_NUL && !state_ff.bsl &&
       state_ff.tail == TAIL_NONE) |=> (state_ff == SCAN_RESET))
      else $error("scan state kept after end of unit");
`endif

endmodule

>>> dv/tb.sv
module tb;
   import stcs_pkg::*;

   logic clock;
   logic reset;

   stcs_req_if req_if ();
   stcs_rsp_if rsp_if ();

   source_text_comment_stripper DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   tail_type                  nl_tail;
   logic                      bsl_held;
   logic                      slash_held;
   cmode_type                 cmode;
   logic [LINE_WIDTH_DEF-1:0] line_cnt;
   logic                      unit_end;

   rsp_entry_type     step_q[$];
   rsp_entry_type     clean_q[$];
   logic [BYTE_W-1:0] src_q[$];
   rsp_entry_type     mon_want;
   rsp_entry_type     mon_got;

   int fail_cnt = 0;
   int fed_cnt = 0;
   int rsp_cnt = 0;
   int unit_cnt = 0;
   int err_cnt = 0;
   int n_src = 0;
   int send_gap = 0;
   int stall_cnt = 0;
   int send_calm = 0;
   int recv_calm = 0;

   task automatic clear_scan();
      nl_tail = TAIL_NONE;
      bsl_held = 1'b0;
      slash_held = 1'b0;
      cmode = CM_OUT;
      line_cnt = LINE_WIDTH_DEF'(1);
   endtask

   task automatic emit_char(input logic [BYTE_W-1:0] ch, input logic err);
      rsp_entry_type e;
      e = '0;
      e.out_byte = ch;
      e.error = err;
      step_q.push_back(e);
   endtask

   task automatic bump_line();
      if (line_cnt != '1)
         line_cnt = line_cnt + LINE_WIDTH_DEF'(1);
   endtask

   // one character after splice removal
   task automatic scan_logical(input logic [BYTE_W-1:0] ch);
      if (unit_end)
         return;
      case (cmode)
         CM_OUT: begin
            if (slash_held) begin
               slash_held = 1'b0;
               if (ch == CH_SLASH) begin
                  cmode = CM_LINE;
                  return;
               end
               if (ch == CH_STAR) begin
                  cmode = CM_BLOCK;
                  return;
               end
               emit_char(CH_SLASH, 1'b0);
            end else if (ch == CH_SLASH) begin
               slash_held = 1'b1;
               return;
            end
            emit_char(ch, 1'b0);
            if (ch == CH_NUL)
               unit_end = 1'b1;
         end
         CM_LINE: begin
            if (ch == CH_LF) begin
               emit_char(CH_LF, 1'b0);
               cmode = CM_OUT;
            end else if (ch == CH_NUL) begin
               emit_char(CH_NUL, 1'b0);
               unit_end = 1'b1;
            end
         end
         default: begin
            if (ch == CH_NUL) begin
               emit_char(CH_NUL, 1'b1);
               unit_end = 1'b1;
               err_cnt++;
            end else if (cmode == CM_STAR && ch == CH_SLASH) begin
               emit_char(CH_SPACE, 1'b0);
               cmode = CM_OUT;
            end else if (ch == CH_STAR) begin
               cmode = CM_STAR;
            end else begin
               if (ch == CH_LF)
                  emit_char(CH_LF, 1'b0);
               cmode = CM_BLOCK;
            end
         end
      endcase
   endtask

   task automatic strip_byte(input logic [BYTE_W-1:0] c);
      logic                  is_nl;
      logic [LINE_NUM_W-1:0] ln;
      is_nl = (c == CH_LF) || (c == CH_CR);
      step_q.delete();
      unit_end = 1'b0;
      if ((nl_tail == TAIL_CR && c == CH_CR) || (nl_tail == TAIL_LF && c == CH_LF)) begin
         nl_tail = TAIL_NONE;
         return;
      end
      nl_tail = TAIL_NONE;
      if (bsl_held && is_nl) begin
         bsl_held = 1'b0;
         bump_line();
         nl_tail = (c == CH_LF) ? TAIL_CR : TAIL_LF;
      end else begin
         if (bsl_held) begin
            bsl_held = 1'b0;
            scan_logical(CH_BSL);
         end
         if (c == CH_BSL) begin
            bsl_held = 1'b1;
         end else if (is_nl) begin
            bump_line();
            nl_tail = (c == CH_LF) ? TAIL_CR : TAIL_LF;
            scan_logical(CH_LF);
         end else begin
            scan_logical(c);
         end
      end
      ln = line_cnt[LINE_NUM_W-1:0];
      if (unit_end) begin
         clear_scan();
         unit_cnt++;
      end
      foreach (step_q[k]) begin
         if (k < MAX_RESULTS) begin
            step_q[k].line_number = ln;
            step_q[k].last = (k == step_q.size() - 1) || (k == MAX_RESULTS - 1);
            clean_q.push_back(step_q[k]);
         end
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35) return BYTE_W'($urandom_range(8'h20, 8'h7E));
      if (r < 50) return BYTE_W'($urandom_range(1, 255));
      if (r < 60) return CH_SLASH;
      if (r < 70) return CH_STAR;
      if (r < 77) return CH_BSL;
      if (r < 88) return CH_LF;
      if (r < 98) return CH_CR;
      return CH_NUL;
   endfunction

   function automatic int pick_idle(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.in_byte <= '0;
         send_gap <= 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            strip_byte(req_if.in_byte);
            fed_cnt++;
         end
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_if.valid <= 1'b0;
         end else if (src_q.size() > 0) begin
            req_if.valid <= 1'b1;
            req_if.in_byte <= src_q.pop_front();
            send_gap <= pick_idle(send_calm);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_cnt++;
            mon_got.out_byte = rsp_if.out_byte;
            mon_got.line_number = rsp_if.line_number;
            mon_got.error = rsp_if.error;
            mon_got.last = rsp_if.last;
            if (clean_q.size() == 0) begin
               $display("%0t: unexpected item byte %h line %0d error %b last %b", $time,
                        mon_got.out_byte, mon_got.line_number, mon_got.error, mon_got.last);
               fail_cnt++;
            end else begin
               mon_want = clean_q.pop_front();
               if (mon_got !== mon_want) begin
                  $display("%0t: mismatch expected byte %h line %0d error %b last %b", $time,
                           mon_want.out_byte, mon_want.line_number, mon_want.error,
                           mon_want.last);
                  $display("%0t:          actual   byte %h line %0d error %b last %b", $time,
                           mon_got.out_byte, mon_got.line_number, mon_got.error,
                           mon_got.last);
                  fail_cnt++;
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            stall_cnt <= pick_idle(recv_calm);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.in_byte = '0;
      rsp_if.ready = 1'b0;
      clear_scan();

      // newline forms, splices, flushed slash and backslash, comments, end of unit
      src_q = '{8'hFF, CH_LF, CH_CR, CH_CR, CH_LF, CH_BSL, CH_CR, CH_LF,
                CH_SLASH, CH_BSL, CH_STAR,
                CH_SLASH, CH_SLASH, CH_CR,
                CH_SLASH, CH_STAR, CH_LF, CH_STAR, CH_SLASH,
                CH_SLASH, CH_STAR, CH_NUL,
                CH_SLASH, CH_BSL, CH_NUL};

      while (src_q.size() < 480) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: src_q.push_back(pick_char());
            4: begin
               src_q.push_back(CH_SLASH);
               src_q.push_back(CH_STAR);
            end
            5: begin
               src_q.push_back(CH_STAR);
               src_q.push_back(CH_SLASH);
            end
            6: begin
               src_q.push_back(CH_SLASH);
               src_q.push_back(CH_SLASH);
            end
            7: begin
               src_q.push_back(CH_BSL);
               src_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            8: begin
               if ($urandom_range(0, 1)) begin
                  src_q.push_back(CH_LF);
                  src_q.push_back(CH_CR);
               end else begin
                  src_q.push_back(CH_CR);
                  src_q.push_back(CH_LF);
               end
            end
            default: begin
               // comment opener split by a splice
               src_q.push_back(CH_SLASH);
               src_q.push_back(CH_BSL);
               src_q.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
               src_q.push_back($urandom_range(0, 1) ? CH_STAR : CH_SLASH);
            end
         endcase
         if ($urandom_range(0, 39) == 0)
            src_q.push_back(CH_NUL);
      end
      src_q.push_back(CH_NUL);
      n_src = src_q.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (fed_cnt < n_src || clean_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d source bytes fed, %0d cleaned items checked", fed_cnt, rsp_cnt);
      $display("%0d units ended, %0d of them inside an open block comment", unit_cnt, err_cnt);
      if (fail_cnt == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #20000000;
      $display("%0t: timeout, %0d items still expected", $time, clean_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
